// File: sv/snc_pkg.sv
// Shared types and constants of the SPI NOR command sequencer.
// No dependencies; used by every module of the block.
`default_nettype none
package snc_pkg;

    localparam int QDEPTH = 2;

    localparam logic [7:0] CMD_READ4   = 8'hEC;
    localparam logic [7:0] CMD_PROG4   = 8'h12;
    localparam logic [7:0] CMD_SECT4   = 8'hDC;
    localparam logic [7:0] CMD_BULK    = 8'hC7;
    localparam logic [7:0] CMD_WREN    = 8'h06;
    localparam logic [7:0] CMD_RDSR    = 8'h05;
    localparam logic [7:0] CLOCK_BYTE  = 8'hFF;
    localparam logic [3:0] DUMMY_RESET = 4'd10;

    typedef enum logic [2:0] {
        MODE_READ  = 3'd0,
        MODE_WRITE = 3'd1,
        MODE_WDATA = 3'd2,
        MODE_SECT  = 3'd3,
        MODE_BULK  = 3'd4,
        MODE_RX    = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        KIND_SPI  = 2'd0,
        KIND_HOST = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_ZERO  = 2'd2,
        ST_UNEXP = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OPN_NONE   = 3'd0,
        OPN_READ   = 3'd1,
        OPN_WRITE  = 3'd2,
        OPN_SECTOR = 3'd3,
        OPN_BULK   = 3'd4
    } pend_t;

    // Byte scripts the back end expands
    typedef enum logic [2:0] {
        SEQ_FIN    = 3'd0,
        SEQ_POLL   = 3'd1,
        SEQ_RDHDR  = 3'd2,
        SEQ_WRPAGE = 3'd3,
        SEQ_SECTOR = 3'd4,
        SEQ_BULK   = 3'd5,
        SEQ_DUMMY  = 3'd6,
        SEQ_WBYTE  = 3'd7
    } seq_t;

    typedef struct packed {
        logic        host_vld;
        logic [7:0]  host;
        seq_t        seq;
        logic [31:0] addr;
        logic [7:0]  data;
        logic [3:0]  cnt;
        logic        flag;
        status_t     status;
    } desc_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] spi_byte;
        logic       cs_release;
        logic       want_reply;
        logic [7:0] host_data;
        status_t    status;
        logic       last;
    } result_t;

endpackage
`default_nettype wire

// File: sv/snc_front.sv
// Front end: accepts input words, keeps the sequencer state and issues
// one byte-script descriptor per word. Depends on snc_pkg.
`default_nettype none
module snc_front import snc_pkg::*; #(
    parameter int               PAGE_BYTES   = 256,
    parameter int               SECTOR_BYTES = 65536,
    parameter longint unsigned  FLASH_BYTES  = 64'd67108864
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    input  wire logic [31:0] address,
    input  wire logic [31:0] length,
    input  wire logic [7:0]  data_byte,
    input  wire logic [3:0]  dummy_bytes,
    output logic             push,
    output desc_t            desc,
    input  wire logic        q_full
);
    localparam int PLW = $clog2(PAGE_BYTES + 1);
    localparam int POW = $clog2(PAGE_BYTES);
    localparam int SOW = $clog2(SECTOR_BYTES);

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_POLL_PRE  = 6'b000010,
        PH_POLL_POST = 6'b000100,
        PH_READ_HDR  = 6'b001000,
        PH_READ_DATA = 6'b010000,
        PH_WRITE     = 6'b100000
    } phase_t;

    phase_t          phase_reg, phase_next;
    pend_t           pend_reg, pend_next;
    logic [31:0]     addr_reg, addr_next;
    logic [31:0]     rem_reg, rem_next;
    logic [PLW-1:0]  page_reg, page_next;
    logic [32:0]     sum;
    logic [PLW-1:0]  room;
    logic [PLW-1:0]  page_fill;
    logic [31:0]     rem_dec;

    assign in_ready  = !q_full;
    assign push      = in_valid && in_ready;
    assign sum       = {1'b0, address} + {1'b0, length};
    assign room      = PLW'(PAGE_BYTES) - PLW'(addr_reg[POW-1:0]);
    assign page_fill = (32'(room) > rem_reg) ? rem_reg[PLW-1:0] : room;
    assign rem_dec   = rem_reg - 32'd1;

    always_comb
    begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        page_next  = page_reg;
        desc       = '0;
        desc.seq    = SEQ_FIN;
        desc.status = ST_UNEXP;
        desc.addr   = addr_reg;
        unique case (mode)
            MODE_READ, MODE_WRITE, MODE_SECT, MODE_BULK:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if ((mode == MODE_READ || mode == MODE_WRITE)
                        && sum > 33'(FLASH_BYTES))
                        desc.status = ST_RANGE;
                    else if ((mode == MODE_READ || mode == MODE_WRITE) && length == 32'd0)
                        desc.status = ST_ZERO;
                    else if (mode == MODE_SECT && 33'(address) >= 33'(FLASH_BYTES))
                        desc.status = ST_RANGE;
                    else
                    begin
                        desc.seq   = SEQ_POLL;
                        phase_next = PH_POLL_PRE;
                        addr_next  = address;
                        unique case (mode)
                            MODE_READ:
                            begin
                                pend_next = OPN_READ;
                                rem_next  = length;
                            end
                            MODE_WRITE:
                            begin
                                pend_next = OPN_WRITE;
                                rem_next  = length;
                            end
                            MODE_SECT:
                            begin
                                pend_next = OPN_SECTOR;
                                addr_next = {address[31:SOW], SOW'(0)};
                            end
                            default: pend_next = OPN_BULK;
                        endcase
                    end
                end
            end
            MODE_WDATA:
            begin
                if (phase_reg == PH_WRITE && page_reg != '0)
                begin
                    page_next = page_reg - PLW'(1);
                    rem_next  = rem_dec;
                    addr_next = addr_reg + 32'd1;
                    desc.seq  = SEQ_WBYTE;
                    desc.data = data_byte;
                    desc.flag = (page_reg == PLW'(1));
                    if (page_reg == PLW'(1))
                        phase_next = PH_POLL_POST;
                end
            end
            MODE_RX:
            begin
                unique case (phase_reg)
                    PH_POLL_PRE, PH_POLL_POST:
                    begin
                        if (data_byte[0])
                            desc.seq = SEQ_POLL;
                        else if (phase_reg == PH_POLL_PRE && pend_reg == OPN_READ)
                        begin
                            desc.seq   = SEQ_RDHDR;
                            phase_next = PH_READ_HDR;
                        end
                        else if (pend_reg == OPN_WRITE
                                 && (phase_reg == PH_POLL_PRE || rem_reg != 32'd0))
                        begin
                            desc.seq   = SEQ_WRPAGE;
                            page_next  = page_fill;
                            phase_next = PH_WRITE;
                        end
                        else if (phase_reg == PH_POLL_PRE && pend_reg == OPN_SECTOR)
                        begin
                            desc.seq   = SEQ_SECTOR;
                            phase_next = PH_POLL_POST;
                        end
                        else if (phase_reg == PH_POLL_PRE && pend_reg == OPN_BULK)
                        begin
                            desc.seq   = SEQ_BULK;
                            phase_next = PH_POLL_POST;
                        end
                        else
                        begin
                            desc.status = ST_OK;
                            phase_next  = PH_IDLE;
                            pend_next   = OPN_NONE;
                        end
                    end
                    PH_READ_HDR:
                    begin
                        desc.seq   = SEQ_DUMMY;
                        desc.cnt   = dummy_bytes;
                        desc.flag  = (rem_reg == 32'd1);
                        phase_next = PH_READ_DATA;
                    end
                    PH_READ_DATA:
                    begin
                        desc.host_vld = 1'b1;
                        desc.host     = data_byte;
                        rem_next      = rem_dec;
                        addr_next     = addr_reg + 32'd1;
                        if (rem_dec != 32'd0)
                        begin
                            desc.seq  = SEQ_DUMMY;
                            desc.flag = (rem_dec == 32'd1);
                        end
                        else
                        begin
                            desc.status = ST_OK;
                            phase_next  = PH_IDLE;
                            pend_next   = OPN_NONE;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pend_reg  <= OPN_NONE;
            addr_reg  <= '0;
            rem_reg   <= '0;
            page_reg  <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            addr_reg  <= addr_next;
            rem_reg   <= rem_next;
            page_reg  <= page_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/snc_queue.sv
// Two-entry descriptor queue between front and back ends.
// Depends on snc_pkg.
`default_nettype none
module snc_queue import snc_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  desc_t      wr_desc,
    output logic       full,
    input  wire logic  pop,
    output logic       not_empty,
    output desc_t      rd_desc
);
    localparam int AW = $clog2(QDEPTH);

    desc_t                   mem [QDEPTH];
    logic [AW-1:0]           wp_reg, rp_reg;
    logic [$clog2(QDEPTH+1)-1:0] cnt_reg;

    assign full      = (cnt_reg == ($clog2(QDEPTH+1))'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rd_desc   = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(QDEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (pop)
                rp_reg <= (rp_reg == AW'(QDEPTH - 1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + ($clog2(QDEPTH+1))'(push) - ($clog2(QDEPTH+1))'(pop);
        end
    end

endmodule
`default_nettype wire

// File: sv/snc_back.sv
// Back end: expands descriptors into result words, one per cycle unless the output
// stalls, into an output register. Depends on snc_pkg.
`default_nettype none
module snc_back import snc_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_not_empty,
    input  desc_t      q_desc,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_word
);
    desc_t        cur_reg;
    logic         busy_reg;
    logic [4:0]   idx_reg;
    logic         vld_reg;
    result_t      word_reg;
    result_t      w;
    logic [4:0]   seq_len;
    logic [4:0]   s;
    logic [4:0]   total;
    logic         advance;
    logic         final_step;

    function automatic logic [7:0] abyte(input logic [31:0] a, input logic [1:0] k);
        logic [7:0] r;
        unique case (k)
            2'd0: r = a[31:24];
            2'd1: r = a[23:16];
            2'd2: r = a[15:8];
            default: r = a[7:0];
        endcase
        return r;
    endfunction

    always_comb
    begin
        unique case (cur_reg.seq)
            SEQ_FIN:    seq_len = 5'd1;
            SEQ_POLL:   seq_len = 5'd2;
            SEQ_RDHDR:  seq_len = 5'd5;
            SEQ_WRPAGE: seq_len = 5'd6;
            SEQ_SECTOR: seq_len = 5'd8;
            SEQ_BULK:   seq_len = 5'd4;
            SEQ_DUMMY:  seq_len = 5'(cur_reg.cnt) + 5'd1;
            default:    seq_len = cur_reg.flag ? 5'd3 : 5'd1;
        endcase
        total      = seq_len + 5'(cur_reg.host_vld);
        s          = idx_reg - 5'(cur_reg.host_vld);
        final_step = (idx_reg == total - 5'd1);

        w            = '0;
        w.kind       = KIND_SPI;
        w.status     = ST_OK;
        w.last       = final_step;
        if (cur_reg.host_vld && idx_reg == 5'd0)
        begin
            w.kind      = KIND_HOST;
            w.host_data = cur_reg.host;
        end
        else
        begin
            unique case (cur_reg.seq)
                SEQ_FIN:
                begin
                    w.kind   = KIND_DONE;
                    w.status = cur_reg.status;
                end
                SEQ_POLL:
                begin
                    w.spi_byte   = (s == 5'd0) ? CMD_RDSR : CLOCK_BYTE;
                    w.cs_release = (s == 5'd1);
                    w.want_reply = (s == 5'd1);
                end
                SEQ_RDHDR:
                begin
                    w.spi_byte   = (s == 5'd0) ? CMD_READ4
                                 : abyte(cur_reg.addr, 2'(s - 5'd1));
                    w.want_reply = (s == 5'd4);
                end
                SEQ_WRPAGE:
                begin
                    w.spi_byte   = (s == 5'd0) ? CMD_WREN
                                 : (s == 5'd1) ? CMD_PROG4
                                 : abyte(cur_reg.addr, 2'(s - 5'd2));
                    w.cs_release = (s == 5'd0);
                end
                SEQ_SECTOR:
                begin
                    w.spi_byte   = (s == 5'd0) ? CMD_WREN
                                 : (s == 5'd1) ? CMD_SECT4
                                 : (s == 5'd6) ? CMD_RDSR
                                 : (s == 5'd7) ? CLOCK_BYTE
                                 : abyte(cur_reg.addr, 2'(s - 5'd2));
                    w.cs_release = (s == 5'd0) || (s == 5'd5) || (s == 5'd7);
                    w.want_reply = (s == 5'd7);
                end
                SEQ_BULK:
                begin
                    w.spi_byte   = (s == 5'd0) ? CMD_WREN
                                 : (s == 5'd1) ? CMD_BULK
                                 : (s == 5'd2) ? CMD_RDSR : CLOCK_BYTE;
                    w.cs_release = (s != 5'd2);
                    w.want_reply = (s == 5'd3);
                end
                SEQ_DUMMY:
                begin
                    if (s == 5'(cur_reg.cnt))
                    begin
                        w.spi_byte   = CLOCK_BYTE;
                        w.cs_release = cur_reg.flag;
                        w.want_reply = 1'b1;
                    end
                end
                default:
                begin
                    w.spi_byte   = (s == 5'd0) ? cur_reg.data
                                 : (s == 5'd1) ? CMD_RDSR : CLOCK_BYTE;
                    w.cs_release = (s == 5'd0) ? cur_reg.flag : (s == 5'd2);
                    w.want_reply = (s == 5'd2);
                end
            endcase
        end
    end

    assign advance   = busy_reg && (!vld_reg || out_ready);
    assign pop       = q_not_empty && (!busy_reg || (advance && final_step));
    assign out_valid = vld_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_desc;
        if (advance)
            word_reg <= w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            vld_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
                vld_reg <= 1'b1;
            else if (out_ready)
                vld_reg <= 1'b0;
            if (pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 5'd1;
                if (final_step)
                    busy_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/spi_nor_command_sequencer.sv
// An accepted word is held in the queue, then the back-end descriptor register, then
// the output register. Results leave one per cycle unless the sink stalls, up to
// seventeen per word, back to back across words when the next descriptor is queued.
// Throughput is set by the back-end expander: one result per clock unless stalled.
// The front end takes a word each cycle while its two-entry queue has room.
// Reset (rst_n, asynchronous, active low) returns to idle with dummy_bytes = 10.
`default_nettype none
module spi_nor_command_sequencer import snc_pkg::*; #(
    parameter int              PAGE_BYTES   = 256,
    parameter int              SECTOR_BYTES = 65536,
    parameter longint unsigned FLASH_BYTES  = 64'd67108864
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: address[31:0], length[63:32], data_byte[71:64]
    input  wire logic [71:0] s_axis_tdata,
    // tuser: mode[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: spi_byte[7:0], cs_release[8], want_reply[9], host_data[17:10],
    //        status[19:18], zero[23:20]
    output logic [23:0]      m_axis_tdata,
    // tuser: kind[1:0]
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    // The front end owns all sequencer state and turns every input word into a
    // compact descriptor naming a byte script; the back end walks the script and
    // emits result words. Because state moves at acceptance, the front can take the
    // next word while the back is still shifting out the previous script.

    logic [3:0] dummy_reg;
    logic       q_full, q_not_empty, push, pop;
    desc_t      f_desc, q_desc;
    result_t    word;

    assign pready = 1'b1;
    assign prdata = {28'd0, dummy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dummy_reg <= DUMMY_RESET;
        else if (psel && penable && pwrite && !paddr[2])
            dummy_reg <= pwdata[3:0];
    end

    snc_front #(
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .FLASH_BYTES  (FLASH_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .mode        (s_axis_tuser),
        .address     (s_axis_tdata[31:0]),
        .length      (s_axis_tdata[63:32]),
        .data_byte   (s_axis_tdata[71:64]),
        .dummy_bytes (dummy_reg),
        .push        (push),
        .desc        (f_desc),
        .q_full      (q_full)
    );

    snc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_desc   (f_desc),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .rd_desc   (q_desc)
    );

    snc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_desc      (q_desc),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_word    (word)
    );

    assign m_axis_tdata = {4'd0, word.status, word.host_data, word.want_reply,
                           word.cs_release, word.spi_byte};
    assign m_axis_tuser = word.kind;
    assign m_axis_tlast = word.last;

    // The front never writes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("descriptor queue overflow");

    // No result word carries the unused kind code.
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("illegal result kind");

    // SPI bytes carry neither host data nor a status.
    a_spi_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_SPI) |-> (m_axis_tdata[19:10] == 10'd0))
        else $error("SPI word with stray fields");

    // A completion word always ends the results of its input word.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_DONE) |-> m_axis_tlast)
        else $error("completion not marked last");

endmodule
`default_nettype wire

// File: verif/tb_spi_nor_command_sequencer.sv
// Self-checking testbench for spi_nor_command_sequencer: drives host requests and
// flash replies as stream words, predicts every framed result and checks it.
// Depends on snc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_spi_nor_command_sequencer;
    import snc_pkg::*;

    localparam longint FLASH_SIZE  = 64'd67108864;
    localparam int     SECTOR_SIZE = 65536;
    localparam int     PAGE_SIZE   = 256;
    // Modes six and seven are not defined and must be refused.
    localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
    localparam logic [2:0] ADDR_DUMMY_BYTES = 3'd0;

    // Where the sequencer stands between two input words.
    typedef enum int {
        FL_IDLE, FL_POLL_BEFORE, FL_POLL_AFTER, FL_READ_HEADER, FL_READ_DATA, FL_PAGE_DATA
    } flow_t;

    // Predicts the framed SPI bytes of each accepted word and checks the results.
    class nor_frame_scoreboard;
        result_t     expected_frames[$];
        flow_t       phase;
        pend_t       pending;
        logic [31:0] cur_addr;
        logic [31:0] remaining;
        int          page_left;
        int          dummy;
        int          failures;

        function new();
            phase = FL_IDLE;
            pending = OPN_NONE;
            cur_addr = 0;
            remaining = 0;
            page_left = 0;
            dummy = int'(DUMMY_RESET);
            failures = 0;
        endfunction

        function void emit(kind_t k, logic [7:0] b, logic rel, logic want, logic [7:0] host,
                           status_t st);
            result_t r;
            r.kind = k;
            r.spi_byte = b;
            r.cs_release = rel;
            r.want_reply = want;
            r.host_data = host;
            r.status = st;
            r.last = 1'b0;
            expected_frames.push_back(r);
        endfunction

        function void send(logic [7:0] b, logic rel, logic want);
            emit(KIND_SPI, b, rel, want, 8'h00, ST_OK);
        endfunction

        function void complete(status_t st);
            emit(KIND_DONE, 8'h00, 1'b0, 1'b0, 8'h00, st);
        endfunction

        function void op_done();
            complete(ST_OK);
            phase = FL_IDLE;
            pending = OPN_NONE;
        endfunction

        function void poll();
            send(CMD_RDSR, 1'b0, 1'b0);
            send(CLOCK_BYTE, 1'b1, 1'b1);
        endfunction

        function void addr4(logic [31:0] a, logic rel, logic want);
            send(a[31:24], 1'b0, 1'b0);
            send(a[23:16], 1'b0, 1'b0);
            send(a[15:8], 1'b0, 1'b0);
            send(a[7:0], rel, want);
        endfunction

        function void open_page();
            longint room;
            room = PAGE_SIZE - (cur_addr % PAGE_SIZE);
            send(CMD_WREN, 1'b1, 1'b0);
            send(CMD_PROG4, 1'b0, 1'b0);
            addr4(cur_addr, 1'b0, 1'b0);
            page_left = (room > longint'(remaining)) ? int'(remaining) : int'(room);
            phase = FL_PAGE_DATA;
        endfunction

        function void start_op();
            case (pending)
                OPN_READ:
                begin
                    send(CMD_READ4, 1'b0, 1'b0);
                    addr4(cur_addr, 1'b0, 1'b1);
                    phase = FL_READ_HEADER;
                end
                OPN_WRITE: open_page();
                OPN_SECTOR:
                begin
                    send(CMD_WREN, 1'b1, 1'b0);
                    send(CMD_SECT4, 1'b0, 1'b0);
                    addr4(cur_addr, 1'b1, 1'b0);
                    poll();
                    phase = FL_POLL_AFTER;
                end
                OPN_BULK:
                begin
                    send(CMD_WREN, 1'b1, 1'b0);
                    send(CMD_BULK, 1'b1, 1'b0);
                    poll();
                    phase = FL_POLL_AFTER;
                end
                default: op_done();
            endcase
        endfunction

        function void request(pend_t op, logic [31:0] a, logic [31:0] len);
            logic [32:0] span;
            span = {1'b0, a} + {1'b0, len};
            if (op == OPN_READ || op == OPN_WRITE)
            begin
                if (longint'(span) > FLASH_SIZE)
                begin
                    complete(ST_RANGE);
                    return;
                end
                if (len == 0)
                begin
                    complete(ST_ZERO);
                    return;
                end
                remaining = len;
            end
            else if (op == OPN_SECTOR)
            begin
                if (longint'(a) >= FLASH_SIZE)
                begin
                    complete(ST_RANGE);
                    return;
                end
                a = a - (a % SECTOR_SIZE);
            end
            cur_addr = a;
            pending = op;
            poll();
            phase = FL_POLL_BEFORE;
        endfunction

        function void received(logic [7:0] b);
            case (phase)
                FL_POLL_BEFORE:
                    if (b[0]) poll();
                    else start_op();
                FL_POLL_AFTER:
                    if (b[0]) poll();
                    else if (pending == OPN_WRITE && remaining != 0) open_page();
                    else op_done();
                FL_READ_HEADER:
                begin
                    repeat (dummy) send(8'h00, 1'b0, 1'b0);
                    send(CLOCK_BYTE, remaining == 1, 1'b1);
                    phase = FL_READ_DATA;
                end
                FL_READ_DATA:
                begin
                    emit(KIND_HOST, 8'h00, 1'b0, 1'b0, b, ST_OK);
                    remaining--;
                    cur_addr++;
                    if (remaining != 0) send(CLOCK_BYTE, remaining == 1, 1'b1);
                    else op_done();
                end
                default: complete(ST_UNEXP);
            endcase
        endfunction

        function void program_byte(logic [7:0] b);
            page_left--;
            remaining--;
            cur_addr++;
            send(b, page_left == 0, 1'b0);
            if (page_left == 0)
            begin
                poll();
                phase = FL_POLL_AFTER;
            end
        endfunction

        // Called for each word the block accepts.
        function void note_word(logic [2:0] mode, logic [31:0] a, logic [31:0] len,
                                logic [7:0] b);
            int first;
            first = expected_frames.size();
            case (mode)
                MODE_READ, MODE_WRITE, MODE_SECT, MODE_BULK:
                    if (phase != FL_IDLE) complete(ST_UNEXP);
                    else if (mode == MODE_READ) request(OPN_READ, a, len);
                    else if (mode == MODE_WRITE) request(OPN_WRITE, a, len);
                    else if (mode == MODE_SECT) request(OPN_SECTOR, a, len);
                    else request(OPN_BULK, a, len);
                MODE_WDATA:
                    if (phase == FL_PAGE_DATA && page_left != 0) program_byte(b);
                    else complete(ST_UNEXP);
                MODE_RX: received(b);
                default: complete(ST_UNEXP);
            endcase
            if (expected_frames.size() == first) complete(ST_UNEXP);
            expected_frames[$].last = 1'b1;
        endfunction

        // Called for each result word the block hands over.
        function void check_word(result_t got);
            result_t want;
            if (expected_frames.size() == 0)
            begin
                $error("result word with nothing expected: kind %0d", got.kind);
                failures++;
                return;
            end
            want = expected_frames.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                failures++;
            end
            if (got.spi_byte !== want.spi_byte)
            begin
                $error("spi_byte: expected %0h, got %0h", want.spi_byte, got.spi_byte);
                failures++;
            end
            if (got.cs_release !== want.cs_release)
            begin
                $error("cs_release: expected %0d, got %0d", want.cs_release, got.cs_release);
                failures++;
            end
            if (got.want_reply !== want.want_reply)
            begin
                $error("want_reply: expected %0d, got %0d", want.want_reply, got.want_reply);
                failures++;
            end
            if (got.host_data !== want.host_data)
            begin
                $error("host_data: expected %0h, got %0h", want.host_data, got.host_data);
                failures++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // tdata: address[31:0], length[63:32], data_byte[71:64]
    logic [71:0] s_axis_tdata;
    // tuser: mode[2:0]
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tdata: spi_byte[7:0], cs_release[8], want_reply[9], host_data[17:10], status[19:18]
    logic [23:0] m_axis_tdata;
    // tuser: kind[1:0]
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nor_frame_scoreboard frames = new();
    int  words_sent = 0;
    // When set, neither side idles, so back-to-back traffic is covered too.
    bit  calm = 0;
    int  sink_stall = 0;

    spi_nor_command_sequencer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Mostly short gaps, now and then a long one; none at all while calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The result sink stalls at random, changing only at falling edges.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (sink_stall > 0)
        begin
            sink_stall <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 20) sink_stall <= pick_gap();
        end
    end

    // Results are taken at the rising edge of each handshake.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind = kind_t'(m_axis_tuser);
            got.spi_byte = m_axis_tdata[7:0];
            got.cs_release = m_axis_tdata[8];
            got.want_reply = m_axis_tdata[9];
            got.host_data = m_axis_tdata[17:10];
            got.status = status_t'(m_axis_tdata[19:18]);
            got.last = m_axis_tlast;
            frames.check_word(got);
        end
    end

    // Presents one word, holds it until accepted and lets the predictor see it.
    task automatic send_word(logic [2:0] mode, logic [31:0] a, logic [31:0] len,
                             logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {b, len, a};
        do @(posedge clk); while (!s_axis_tready);
        frames.note_word(mode, a, len, b);
        words_sent++;
        @(negedge clk);
    endtask

    // A word the block must refuse in its present phase.
    task automatic send_noise();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            send_word(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), $urandom,
                      $urandom, 8'($urandom));
        else if (pick == 1 && frames.phase != FL_PAGE_DATA)
            send_word(MODE_WDATA, $urandom, $urandom, 8'($urandom));
        else if (frames.phase != FL_IDLE)
            send_word(MODE_BULK, $urandom, $urandom, 8'($urandom));
        else
            send_word(MODE_RX, $urandom, $urandom, 8'($urandom));
    endtask

    // Issues a request and then plays the flash side until it completes.
    task automatic run_op(logic [2:0] mode, logic [31:0] a, logic [31:0] len,
                          int wip_pct, int noise_pct);
        logic [7:0] b;
        send_word(mode, a, len, 8'($urandom));
        while (frames.phase != FL_IDLE)
        begin
            b = 8'($urandom);
            if ($urandom_range(0, 99) < noise_pct)
                send_noise();
            else if (frames.phase == FL_PAGE_DATA)
                send_word(MODE_WDATA, $urandom, $urandom, b);
            else
            begin
                if (frames.phase == FL_POLL_BEFORE || frames.phase == FL_POLL_AFTER)
                    b[0] = ($urandom_range(0, 99) < wip_pct);
                send_word(MODE_RX, $urandom, $urandom, b);
            end
        end
    endtask

    // Registers change only once every expected result is out and the block is still.
    task automatic set_dummy(logic [3:0] value);
        s_axis_tvalid <= 1'b0;
        while (frames.expected_frames.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_DUMMY_BYTES;
        pwdata <= {28'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        frames.dummy = int'(value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_op();
        int          r;
        logic [31:0] a;
        logic [31:0] len;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            len = $urandom_range(1, 8);
            a = $urandom_range(0, int'(FLASH_SIZE) - len);
            run_op(MODE_READ, a, len, 15, 4);
        end
        else if (r < 60)
        begin
            len = $urandom_range(1, 20);
            a = ($urandom_range(0, int'(FLASH_SIZE) - 512) & ~32'hFF)
                | $urandom_range(0, 1) * 8'hF0 | $urandom_range(0, 15);
            run_op(MODE_WRITE, a, len, 15, 4);
        end
        else if (r < 72)
            run_op(MODE_SECT, $urandom_range(0, int'(FLASH_SIZE) - 1), $urandom, 15, 4);
        else if (r < 80)
            run_op(MODE_BULK, $urandom, $urandom, 20, 4);
        else if (r < 88)
            // Out of range: addresses at or above the flash size, any length.
            run_op($urandom_range(0, 1) ? MODE_READ : MODE_WRITE, $urandom | 32'h0400_0000,
                   $urandom, 0, 0);
        else if (r < 92)
            run_op(MODE_SECT, $urandom | 32'h0400_0000, $urandom, 0, 0);
        else if (r < 95)
            run_op($urandom_range(0, 1) ? MODE_READ : MODE_WRITE,
                   $urandom_range(0, int'(FLASH_SIZE)), 0, 0, 0);
        else
            send_noise();
    endtask

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: reset dummy count, every request, the corner cases.
        run_op(MODE_READ, 32'h0000_0000, 1, 0, 0);
        run_op(MODE_READ, 32'h03FF_FFFC, 4, 60, 0);
        run_op(MODE_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        run_op(MODE_READ, 32'h0000_0001, 32'h0400_0000, 0, 0);
        run_op(MODE_WRITE, 32'h03FF_FFFF, 0, 0, 0);
        run_op(MODE_WRITE, 32'h0000_01FE, 5, 40, 0);
        run_op(MODE_SECT, 32'h03FF_FFFF, 0, 50, 0);
        run_op(MODE_SECT, 32'h0400_0000, 0, 0, 0);
        run_op(MODE_BULK, 0, 0, 50, 0);
        send_word(MODE_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_word(MODE_UNUSED_HI, 0, 0, 0);
        send_word(MODE_WDATA, 0, 0, 8'hA5);
        send_word(MODE_RX, 0, 0, 8'h5A);
        run_op(MODE_WRITE, 32'h0000_00FF, 2, 0, 50);

        set_dummy(4'd0);
        calm = 1;
        repeat (6) random_op();
        calm = 0;
        set_dummy(4'd15);
        run_op(MODE_READ, 32'h0123_4500, 2, 0, 0);
        set_dummy(4'd0);
        while (words_sent < 100) random_op();
        set_dummy(4'($urandom_range(1, 14)));
        while (words_sent < 160)
        begin
            if ($urandom_range(0, 9) == 0) calm = !calm;
            random_op();
        end
        set_dummy(4'd15);
        while (words_sent < 180) random_op();

        s_axis_tvalid <= 1'b0;
        while (frames.expected_frames.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (frames.failures == 0 && frames.expected_frames.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
